[design/rrts_pkg.sv]
// ----------------------------------------------------------------------------
// rrts_pkg
// Shared types and constants for the round-robin task scheduler.
// ----------------------------------------------------------------------------
`default_nettype none
package rrts_pkg;
  localparam int MaxTasks = 256;
  localparam int IdBits   = 16;
  localparam int SlotW    = $clog2(MaxTasks);
  localparam int CountW   = $clog2(MaxTasks + 1);

  typedef logic [IdBits-1:0] id_t;
  typedef logic [SlotW-1:0]  slot_t;
  typedef logic [CountW-1:0] count_t;

  typedef enum logic [2:0] {
    FN_SCHED = 3'd0,
    FN_ADD   = 3'd1,
    FN_FORK  = 3'd2,
    FN_EXIT  = 3'd3,
    FN_WAIT  = 3'd4
  } func_t;

  typedef enum logic [1:0] {
    ST_READY    = 2'd0,
    ST_WAITING  = 2'd1,
    ST_FINISHED = 2'd2
  } status_t;

  // one slot entry as held in memory
  typedef struct packed {
    id_t             id;
    logic [IdBits:0] parent;
    status_t         status;
    id_t             awaited;
  } entry_t;

  typedef enum logic [3:0] {
    S_IDLE, S_FIND_RD, S_FIND_CHK, S_CHILD_CHK, S_CUR_RD, S_CUR_CHK,
    S_SCH_RD, S_SCH_CHK, S_SCH_FRD, S_SCH_FCHK, S_SCH_CRD, S_SCH_CCHK,
    S_DONE
  } state_t;
endpackage
`default_nettype wire

[design/round_robin_task_scheduler.sv]
// ----------------------------------------------------------------------------
// round_robin_task_scheduler
// Task slot table in one synchronous memory, driven by a sequencer.
// ----------------------------------------------------------------------------
// One item is taken at a time. Add and fork write the new slot straight away
// as the item is accepted. Exit reads, modifies and writes back the current
// slot. Wait searches the table for the lowest slot holding the id. A schedule
// tick walks slots round-robin from the one after the current slot, or from
// slot 0 when there is none. Each waiting slot visited costs an id search
// through the single memory read port. The result sits in an output register
// and the next item is taken once it has been delivered.
`default_nettype none
module round_robin_task_scheduler (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,   // func[2:0], wait_id[18:3], zero
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [47:0]      out_tdata   // ok, has_current, current_slot[7:0],
                                       // current_id[15:0], new_id[15:0], zero
);
  import rrts_pkg::*;

  entry_t mem [MaxTasks];
  entry_t rd_q;
  slot_t  rd_addr;
  logic   we;
  slot_t  wr_addr;
  entry_t wr_data;

  state_t state_r, state_nxt;
  count_t cnt_r, cnt_nxt;
  slot_t  cur_r, cur_nxt;
  logic   curv_r, curv_nxt;
  id_t    nid_r, nid_nxt;
  id_t    curid_r, curid_nxt;
  logic [2:0] func_r, func_nxt;
  id_t    wid_r, wid_nxt;
  slot_t  pos_r, pos_nxt;      // walk position
  count_t left_r, left_nxt;    // slots left in walk
  slot_t  fi_r, fi_nxt;        // search index
  entry_t ent_r, ent_nxt;      // slot under test
  logic   ok_r, ok_nxt;
  id_t    new_r, new_nxt;
  logic   ovld_r, ovld_nxt;
  logic [47:0] odat_r, odat_nxt;

  // memory with registered read
  always_ff @(posedge clk) begin
    if (we) mem[wr_addr] <= wr_data;
    rd_q <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; cnt_r <= '0; cur_r <= '0; curv_r <= 1'b0;
      nid_r <= '0; ovld_r <= 1'b0;
    end else begin
      state_r <= state_nxt; cnt_r <= cnt_nxt; cur_r <= cur_nxt;
      curv_r <= curv_nxt; nid_r <= nid_nxt; ovld_r <= ovld_nxt;
    end
    curid_r <= curid_nxt; func_r <= func_nxt; wid_r <= wid_nxt;
    pos_r <= pos_nxt; left_r <= left_nxt; fi_r <= fi_nxt; ent_r <= ent_nxt;
    ok_r <= ok_nxt; new_r <= new_nxt; odat_r <= odat_nxt;
  end

  assign in_tready  = (state_r == S_IDLE) && !ovld_r;
  assign out_tvalid = ovld_r;
  assign out_tdata  = odat_r;

  slot_t  last_slot;
  slot_t  pos_inc;
  logic   fi_last;
  assign last_slot = slot_t'(cnt_r - count_t'(1));
  assign pos_inc   = (pos_r == last_slot) ? '0 : slot_t'(pos_r + slot_t'(1));
  assign fi_last   = (count_t'(fi_r) + count_t'(1)) >= cnt_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_tvalid && in_tready) begin
        unique case (in_tdata[2:0])
          FN_SCHED: state_nxt = (cnt_r == '0) ? S_DONE : S_SCH_RD;
          FN_EXIT:  state_nxt = curv_r ? S_CUR_RD : S_DONE;
          FN_WAIT:  state_nxt = (!curv_r || in_tdata[18:3] == '0 ||
                                 in_tdata[18:3] == curid_r) ? S_DONE : S_FIND_RD;
          default:  state_nxt = S_DONE;
        endcase
      end
      S_FIND_RD:   state_nxt = S_FIND_CHK;
      S_FIND_CHK:  state_nxt = (rd_q.id == wid_r) ? S_CHILD_CHK :
                               (fi_last ? S_DONE : S_FIND_RD);
      S_CHILD_CHK: state_nxt = (rd_q.status == ST_FINISHED) ? S_DONE : S_CUR_RD;
      S_CUR_RD:    state_nxt = S_CUR_CHK;
      S_CUR_CHK:   state_nxt = S_DONE;
      S_SCH_RD:    state_nxt = S_SCH_CHK;
      S_SCH_CHK: begin
        if (rd_q.status == ST_READY) state_nxt = S_DONE;
        else if (rd_q.status == ST_WAITING) state_nxt = S_SCH_FRD;
        else state_nxt = (left_r == count_t'(1)) ? S_DONE : S_SCH_RD;
      end
      S_SCH_FRD:   state_nxt = S_SCH_FCHK;
      S_SCH_FCHK:  state_nxt = (rd_q.id == ent_r.awaited) ? S_SCH_CRD :
                               (fi_last ? ((left_r == count_t'(1)) ? S_DONE : S_SCH_RD)
                                        : S_SCH_FRD);
      S_SCH_CRD:   state_nxt = S_SCH_CCHK;
      S_SCH_CCHK:  state_nxt = (rd_q.status == ST_FINISHED) ? S_DONE :
                               ((left_r == count_t'(1)) ? S_DONE : S_SCH_RD);
      S_DONE:      state_nxt = S_IDLE;
      default:     state_nxt = S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    cnt_nxt = cnt_r; cur_nxt = cur_r; curv_nxt = curv_r; nid_nxt = nid_r;
    curid_nxt = curid_r; func_nxt = func_r; wid_nxt = wid_r; pos_nxt = pos_r;
    left_nxt = left_r; fi_nxt = fi_r; ent_nxt = ent_r; ok_nxt = ok_r;
    new_nxt = new_r; ovld_nxt = ovld_r; odat_nxt = odat_r;
    rd_addr = fi_r; we = 1'b0; wr_addr = cur_r; wr_data = ent_r;
    if (ovld_r && out_tready) ovld_nxt = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        rd_addr = '0;
        if (in_tvalid && in_tready) begin
          func_nxt = in_tdata[2:0];
          wid_nxt  = in_tdata[18:3];
          ok_nxt = 1'b0; new_nxt = '0; fi_nxt = '0;
          pos_nxt = curv_r ? ((cur_r == last_slot) ? '0 : slot_t'(cur_r + slot_t'(1)))
                           : '0;
          left_nxt = cnt_r;
          unique case (in_tdata[2:0])
            FN_ADD, FN_FORK: if (cnt_r != count_t'(MaxTasks) &&
                                 (in_tdata[2:0] == FN_ADD || curv_r)) begin
              we = 1'b1; wr_addr = slot_t'(cnt_r);
              wr_data.id = nid_r;
              wr_data.parent = (in_tdata[2:0] == FN_ADD) ? '1 : {1'b0, curid_r};
              wr_data.status = ST_READY;
              wr_data.awaited = '1;
              cnt_nxt = cnt_r + count_t'(1);
              nid_nxt = nid_r + id_t'(1);
              new_nxt = nid_r; ok_nxt = 1'b1;
            end
            default: ;
          endcase
        end
      end
      S_FIND_RD: rd_addr = fi_r;
      S_FIND_CHK: if (rd_q.id != wid_r) fi_nxt = slot_t'(fi_r + slot_t'(1));
      S_CHILD_CHK: rd_addr = cur_r;
      S_CUR_RD: rd_addr = cur_r;
      // read-modify-write of the current slot for exit and wait
      S_CUR_CHK: begin
        we = 1'b1; wr_addr = cur_r; wr_data = rd_q; ok_nxt = 1'b1;
        if (func_r == FN_EXIT) begin
          wr_data.status = ST_FINISHED;
        end else begin
          wr_data.status = ST_WAITING; wr_data.awaited = wid_r;
        end
      end
      S_SCH_RD: rd_addr = pos_r;
      S_SCH_CHK: begin
        ent_nxt = rd_q; fi_nxt = '0; rd_addr = '0;
        if (rd_q.status == ST_READY) begin
          cur_nxt = pos_r; curv_nxt = 1'b1; curid_nxt = rd_q.id; ok_nxt = 1'b1;
        end else if (rd_q.status != ST_WAITING) begin
          pos_nxt = pos_inc; left_nxt = left_r - count_t'(1);
        end
      end
      S_SCH_FRD: rd_addr = fi_r;
      S_SCH_FCHK: begin
        rd_addr = fi_r;
        if (rd_q.id != ent_r.awaited) begin
          if (fi_last) begin
            pos_nxt = pos_inc; left_nxt = left_r - count_t'(1);
          end else fi_nxt = slot_t'(fi_r + slot_t'(1));
        end
      end
      S_SCH_CRD: rd_addr = fi_r;
      S_SCH_CCHK: begin
        if (rd_q.status == ST_FINISHED) begin
          we = 1'b1; wr_addr = pos_r; wr_data = ent_r;
          wr_data.status = ST_READY; wr_data.awaited = '0;
          cur_nxt = pos_r; curv_nxt = 1'b1; curid_nxt = ent_r.id; ok_nxt = 1'b1;
        end else begin
          pos_nxt = pos_inc; left_nxt = left_r - count_t'(1);
        end
      end
      S_DONE: begin
        ovld_nxt = 1'b1;
        odat_nxt = {6'd0, new_r, curv_r ? curid_r : id_t'(0),
                    curv_r ? 8'(cur_r) : 8'd0, curv_r, ok_r};
      end
      default: ;
    endcase
  end
endmodule
`default_nettype wire

[tb/round_robin_task_scheduler_tb.sv]
// ----------------------------------------------------------------------------
// round_robin_task_scheduler_tb
// Drives scheduler events through the input stream and checks every result
// against a behavioural model of the slot table, with random idling on both
// sides.
// ----------------------------------------------------------------------------
`default_nettype none
module round_robin_task_scheduler_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rrts_pkg::*;

  localparam int WatchdogLimit = 2000000;
  localparam int RandItems     = 1750;
  localparam int FillAt        = 875;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;

  round_robin_task_scheduler dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  always #1 clk = ~clk;

  // model state of the slot table
  int          m_count;
  int          m_cur;
  bit          m_cur_ok;
  id_t         m_next;
  id_t         m_id [MaxTasks];
  status_t     m_st [MaxTasks];
  id_t         m_aw [MaxTasks];

  logic [23:0] pending_items[$];
  logic [47:0] expected_results[$];
  int          errors = 0;
  bit          hold_off = 1'b0;
  bit          stim_done = 1'b0;

  function automatic int lookup_slot(id_t id);
    for (int i = 0; i < m_count; i++)
      if (m_id[i] == id) return i;
    return -1;
  endfunction

  function automatic id_t create_task();
    id_t id;
    id = m_next;
    m_id[m_count] = id;
    m_st[m_count] = ST_READY;
    m_aw[m_count] = '1;
    m_count++;
    m_next = m_next + 1'b1;
    return id;
  endfunction

  // apply one event to the model and return the packed result
  function automatic logic [47:0] predict_event(logic [2:0] fn, id_t wid);
    bit  ok;
    id_t created;
    int  pos, c;
    ok = 1'b0;
    created = '0;
    if (m_cur_ok && m_cur >= m_count) m_cur_ok = 1'b0;
    case (fn)
      FN_SCHED: begin
        if (m_count > 0) begin
          pos = m_cur_ok ? (m_cur + 1) % m_count : 0;
          for (int i = 0; i < m_count && !ok; i++) begin
            if (m_st[pos] == ST_WAITING) begin
              c = lookup_slot(m_aw[pos]);
              if (c >= 0 && m_st[c] == ST_FINISHED) begin
                m_st[pos] = ST_READY;
                m_aw[pos] = '0;
              end
            end
            if (m_st[pos] == ST_READY) begin
              m_cur = pos;
              m_cur_ok = 1'b1;
              ok = 1'b1;
            end
            pos = (pos + 1) % m_count;
          end
        end
      end
      FN_ADD: if (m_count < MaxTasks) begin
        created = create_task();
        ok = 1'b1;
      end
      FN_FORK: if (m_cur_ok && m_count < MaxTasks) begin
        created = create_task();
        ok = 1'b1;
      end
      FN_EXIT: if (m_cur_ok) begin
        m_st[m_cur] = ST_FINISHED;
        ok = 1'b1;
      end
      FN_WAIT: if (m_cur_ok && wid != 0 && wid != m_id[m_cur]) begin
        c = lookup_slot(wid);
        if (c >= 0 && m_st[c] != ST_FINISHED) begin
          m_st[m_cur] = ST_WAITING;
          m_aw[m_cur] = wid;
          ok = 1'b1;
        end
      end
      default: ;
    endcase
    return {6'd0, created, m_cur_ok ? m_id[m_cur] : id_t'(0),
            m_cur_ok ? 8'(m_cur) : 8'd0, m_cur_ok, ok};
  endfunction

  function automatic logic [23:0] make_item(logic [2:0] fn, id_t wid);
    return {5'd0, wid, fn};
  endfunction

  task automatic predicted_push(logic [23:0] item);
    expected_results.push_back(predict_event(item[2:0], item[18:3]));
  endtask

  // driver: random gap before each item
  int in_gap = 0;
  always @(posedge clk) begin
    int draw;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        predicted_push(in_tdata);
        draw = $urandom_range(0, 4);
        in_gap <= draw;
        if (draw == 0 && !hold_off && pending_items.size() > 0) begin
          in_tdata <= pending_items.pop_front();
        end else begin
          in_tvalid <= 1'b0;
        end
      end else if (!in_tvalid) begin
        if (in_gap > 1) begin
          in_gap <= in_gap - 1;
        end else begin
          in_gap <= 0;
          if (!hold_off && pending_items.size() > 0) begin
            in_tdata  <= pending_items.pop_front();
            in_tvalid <= 1'b1;
          end
        end
      end
    end
  end

  // monitor: compares results and stalls at random
  int out_gap = 0;
  always @(posedge clk) begin
    logic [47:0] exp_r;
    int draw;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result %h", $time, out_tdata);
          errors++;
        end else begin
          exp_r = expected_results.pop_front();
          if (exp_r[0] !== out_tdata[0])
            $display("%0t: ok exp %h got %h", $time, exp_r[0], out_tdata[0]);
          if (exp_r[1] !== out_tdata[1])
            $display("%0t: has_current exp %h got %h", $time, exp_r[1], out_tdata[1]);
          if (exp_r[9:2] !== out_tdata[9:2])
            $display("%0t: current_slot exp %h got %h", $time, exp_r[9:2],
                     out_tdata[9:2]);
          if (exp_r[25:10] !== out_tdata[25:10])
            $display("%0t: current_id exp %h got %h", $time, exp_r[25:10],
                     out_tdata[25:10]);
          if (exp_r[41:26] !== out_tdata[41:26])
            $display("%0t: new_id exp %h got %h", $time, exp_r[41:26],
                     out_tdata[41:26]);
          if (exp_r[47:42] !== out_tdata[47:42])
            $display("%0t: padding exp %h got %h", $time, exp_r[47:42],
                     out_tdata[47:42]);
          if (exp_r !== out_tdata) errors++;
        end
        draw = $urandom_range(0, 4);
        out_gap <= draw;
        out_tready <= (draw == 0);
      end else if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_tready <= (out_gap == 1);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // watchdog on cycles without any handshake
  int idle_cycles = 0;
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // plan items against a shadow model so waits can target live ids
  int sh_count;
  id_t sh_next;
  task automatic plan(logic [2:0] fn, id_t wid);
    pending_items.push_back(make_item(fn, wid));
    if ((fn == FN_ADD || fn == FN_FORK) && sh_count < MaxTasks) begin
      sh_count++;
      sh_next++;
    end
  endtask

  initial begin
    logic [2:0] fn;
    int r;
    m_count = 0; m_cur = 0; m_cur_ok = 0; m_next = '0;
    sh_count = 0; sh_next = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty-table and no-current cases, then basic flow
    plan(FN_SCHED, '0);
    plan(FN_FORK, '0);
    plan(FN_EXIT, '0);
    plan(FN_WAIT, 16'd1);
    plan(3'd5, 16'hFFFF);
    plan(3'd7, '0);
    plan(FN_ADD, '0);
    plan(FN_ADD, '0);
    plan(FN_SCHED, '0);
    plan(FN_WAIT, '0);
    plan(FN_WAIT, 16'd2);
    plan(FN_WAIT, 16'hFFFF);
    plan(FN_WAIT, 16'd1);
    plan(FN_SCHED, '0);
    plan(FN_FORK, '0);
    plan(FN_EXIT, '0);
    plan(FN_EXIT, '0);
    plan(FN_FORK, '0);
    plan(FN_SCHED, '0);
    plan(FN_SCHED, '0);
    plan(FN_WAIT, 16'd1);
    plan(FN_SCHED, '0);
    plan(3'd6, 16'hAAAA);

    // pause until every result has come
    wait (pending_items.size() == 0);
    @(posedge clk);
    hold_off = 1'b1;
    wait (expected_results.size() == 0 && !in_tvalid);
    hold_off = 1'b0;

    // random part: few ticks, table kept small, one fill to full capacity
    for (int n = 0; n < RandItems; n++) begin
      if (n == FillAt) begin
        repeat (MaxTasks) plan(FN_ADD, '0);
        plan(FN_ADD, '0);
        plan(FN_FORK, '0);
        plan(FN_SCHED, '0);
      end
      r = $urandom_range(0, 99);
      if (sh_count > 24 && n < FillAt) fn = (r < 50) ? FN_EXIT : FN_WAIT;
      else if (r < 10) fn = FN_SCHED;
      else if (r < 25) fn = FN_ADD;
      else if (r < 40) fn = FN_FORK;
      else if (r < 60) fn = FN_EXIT;
      else if (r < 95) fn = FN_WAIT;
      else fn = 3'($urandom_range(5, 7));
      if (n >= FillAt && fn == FN_SCHED && $urandom_range(0, 3) != 0) fn = FN_EXIT;
      plan(fn, id_t'(n % 2 ? $urandom : (sh_next > 0 ?
           $urandom_range(0, sh_next - 1) : 0)));
    end
    stim_done = 1'b1;
  end

  // end of run
  initial begin
    wait (stim_done && pending_items.size() == 0 && !in_tvalid
          && expected_results.size() == 0);
    repeat (100) @(posedge clk);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire
